/* rtl/core/baro_pkg.sv */
`timescale 1ns / 1ps

package baro_pkg;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_T1_T2 = 3'd0,
		REG_T3_P1 = 3'd1,
		REG_P2_P3 = 3'd2,
		REG_P4_P5 = 3'd3,
		REG_P6_P7 = 3'd4,
		REG_P8_P9 = 3'd5
	} reg_idx_t;

	// Quotient bits resolved by the divider (integer part up to 2^23, 16 fraction bits).
	localparam int DIV_BITS  = 39;
	localparam int FRAC_BITS = 16;
	localparam int INT_SHIFT = 23;

	// Pipeline depth: front end, divider, back end.
	localparam int FRONT_STAGES = 12;
	localparam int BACK_STAGES  = 7;
	localparam int STAGES       = FRONT_STAGES + DIV_BITS + BACK_STAGES;

	// Fixed-point constants of the compensation formula.
	localparam logic signed [19:0] TF_MAX     = 20'sh7ffff;
	localparam logic signed [19:0] TF_MIN     = 20'sh80000;
	localparam logic signed [15:0] TC_MAX     = 16'sh7fff;
	localparam logic signed [15:0] TC_MIN     = 16'sh8000;
	localparam logic [61:0]        TC_HALF    = 62'(1) << 41;
	localparam logic signed [20:0] H_OFFSET   = 21'sd128000;
	localparam logic signed [59:0] A_BIAS     = 60'sd1 <<< 55;
	localparam logic [20:0]        ADC_FULL   = 21'h100000;
	localparam logic signed [13:0] P_SCALE    = 14'sd6250;
	localparam logic [39:0]        P_SAT      = 40'(1) << DIV_BITS;
	localparam logic [48:0]        PA_HALF    = 49'h8000;
	localparam logic [17:0]        PA_MAX     = 18'h3ffff;

	// Results that ride along with the pressure path.
	typedef struct packed {
		logic [15:0] tc;
		logic [19:0] tf;
	} temp_res_t;

	// One stage of the restoring divider.
	typedef struct packed {
		logic [36:0] rem;
		logic [36:0] den;
		logic [22:0] lo;
		logic [38:0] quo;
		logic        neg;
		logic        sat;
		logic        inval;
		temp_res_t   tres;
	} div_stage_t;

endpackage

/* rtl/core/baro_sensor_compensation.sv */
// Barometric sensor compensation pipeline.
// Throughput: one transaction per cycle unless an output stall holds the pipeline.
// The 39-stage restoring divider sets the depth.
// The whole pipeline advances together and holds while a result waits under stall.
// Reset clears the calibration registers and all valid bits; data registers are not reset.
`timescale 1ns / 1ps

module baro_sensor_compensation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [19:0]        raw_pressure,
	input  logic [19:0]        raw_temperature,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] temperature_centi,
	output logic [17:0]        pressure_pa,
	output logic signed [19:0] fine_temperature,
	output logic               invalid,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int LAST_DIV = baro_pkg::FRONT_STAGES + baro_pkg::DIV_BITS;

	// Calibration registers.
	logic [31:0] calib_t1_t2_q, calib_t3_p1_q, calib_p2_p3_q;
	logic [31:0] calib_p4_p5_q, calib_p6_p7_q, calib_p8_p9_q;

	logic [15:0]        t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

	logic                     en;
	logic [baro_pkg::STAGES:1] vld_s;

	// Front-end stage registers.
	logic signed [21:0] d_s1;
	logic [19:0]        adcp_s1, adcp_s2, adcp_s3, adcp_s4, adcp_s5, adcp_s6, adcp_s7, adcp_s8;
	logic signed [37:0] dt2_s2;
	logic signed [41:0] dsq_s2;
	logic signed [59:0] ssum_s3;
	logic [58:0]        smag_s4;
	logic [61:0]        s5mag_s4;
	logic               sneg_s4;
	baro_pkg::temp_res_t tres_s5, tres_s6, tres_s7, tres_s8, tres_s9, tres_s10, tres_s11;
	logic signed [20:0] h_s6;
	logic signed [40:0] hh_s7;
	logic signed [36:0] hp5_s7, hp2_s7;
	logic signed [59:0] n2_s8, a_s8;
	logic signed [53:0] ddp_s9;
	logic signed [45:0] x16_s9;
	logic signed [37:0] dd_s10;
	logic signed [59:0] num_s10;
	logic [58:0]        un_s11;
	logic [36:0]        ud_s11;
	logic               neg_s11, inval_s11;
	baro_pkg::div_stage_t div_s12;
	baro_pkg::div_stage_t div_s [1:baro_pkg::DIV_BITS];

	// Back-end stage registers.
	logic signed [40:0] pq_s52, pq_s53, pq_s54, pq_s55, pq_s56;
	logic [31:0]        sqa_s53;
	logic signed [56:0] p8m_s53;
	logic [63:0]        sq2_s54;
	logic signed [41:0] p8t_s54, p8t_s55;
	logic signed [49:0] m9_s55;
	logic signed [51:0] corr_s56;
	logic signed [48:0] pf_s57;
	baro_pkg::temp_res_t tres_s52, tres_s53, tres_s54, tres_s55, tres_s56, tres_s57;
	logic               inval_s52, inval_s53, inval_s54, inval_s55, inval_s56, inval_s57;
	logic signed [15:0] tc_s58;
	logic signed [19:0] tf_s58;
	logic [17:0]        pa_s58;
	logic               inval_s58;

	// Combinational values.
	logic signed [21:0] d_next;
	logic signed [43:0] dsq_full;
	logic signed [57:0] dsq_t3;
	logic signed [59:0] ssum_next;
	logic signed [62:0] s5x;
	logic [24:0]        tmag;
	logic [20:0]        cq;
	logic signed [19:0] tf_next;
	logic signed [15:0] tc_next;
	logic signed [41:0] hh_full;
	logic signed [56:0] hh_p6, hh_p3;
	logic signed [36:0] a_shr;
	logic [20:0]        pdiff;
	logic signed [60:0] x_diff;
	logic [39:0]        pm;
	logic signed [40:0] pq_next;
	logic signed [32:0] sq_sh;
	logic [32:0]        rq;
	logic [17:0]        pa_next;

	// Configuration write port, always ready.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_t1_t2_q <= '0;
			calib_t3_p1_q <= '0;
			calib_p2_p3_q <= '0;
			calib_p4_p5_q <= '0;
			calib_p6_p7_q <= '0;
			calib_p8_p9_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				baro_pkg::REG_T1_T2: calib_t1_t2_q <= cfg_data;
				baro_pkg::REG_T3_P1: calib_t3_p1_q <= cfg_data;
				baro_pkg::REG_P2_P3: calib_p2_p3_q <= cfg_data;
				baro_pkg::REG_P4_P5: calib_p4_p5_q <= cfg_data;
				baro_pkg::REG_P6_P7: calib_p6_p7_q <= cfg_data;
				baro_pkg::REG_P8_P9: calib_p8_p9_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Coefficients. Unchecked: keep configuration static with transactions in flight.
	assign t1 = calib_t1_t2_q[15:0];
	assign t2 = $signed(calib_t1_t2_q[31:16]);
	assign t3 = $signed(calib_t3_p1_q[15:0]);
	assign p1 = calib_t3_p1_q[31:16];
	assign p2 = $signed(calib_p2_p3_q[15:0]);
	assign p3 = $signed(calib_p2_p3_q[31:16]);
	assign p4 = $signed(calib_p4_p5_q[15:0]);
	assign p5 = $signed(calib_p4_p5_q[31:16]);
	assign p6 = $signed(calib_p6_p7_q[15:0]);
	assign p7 = $signed(calib_p6_p7_q[31:16]);
	assign p8 = $signed(calib_p8_p9_q[15:0]);
	assign p9 = $signed(calib_p8_p9_q[31:16]);

	// The pipeline moves as a whole unless a result is held by the output stall.
	assign en       = !vld_s[baro_pkg::STAGES] || !out_stall;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[baro_pkg::STAGES-1:1], in_valid};
		end
	end

	// Temperature arithmetic.
	always_comb begin
		d_next    = $signed({2'b00, raw_temperature}) - $signed({2'b00, t1, 4'b0000});
		dsq_full  = d_s1 * d_s1;
		dsq_t3    = dsq_s2 * t3;
		ssum_next = (60'(dt2_s2) <<< 20) + 60'(dsq_t3);
		s5x       = (63'(ssum_s3) <<< 2) + 63'(ssum_s3);
	end

	// Truncation, rounding and saturation of the temperature results.
	always_comb begin
		tmag = smag_s4[58:34];
		cq   = 21'((s5mag_s4 + baro_pkg::TC_HALF) >> 42);
		if (sneg_s4) begin
			tf_next = (tmag > 25'd524288) ? baro_pkg::TF_MIN : 20'(-$signed({1'b0, tmag}));
			tc_next = (cq > 21'd32768) ? baro_pkg::TC_MIN : 16'(-$signed({1'b0, cq}));
		end else begin
			tf_next = (tmag > 25'd524287) ? baro_pkg::TF_MAX : 20'(tmag);
			tc_next = (cq > 21'd32767) ? baro_pkg::TC_MAX : 16'(cq);
		end
	end

	// Pressure divisor and dividend arithmetic.
	always_comb begin
		hh_full = h_s6 * h_s6;
		hh_p6   = hh_s7 * p6;
		hh_p3   = hh_s7 * p3;
		a_shr   = $signed(a_s8[59:23]);
		pdiff   = baro_pkg::ADC_FULL - {1'b0, adcp_s8};
		x_diff  = 61'($signed({1'b0, pdiff, 31'b0})) - 61'(n2_s8);
	end

	// Front-end stage registers.
	always_ff @(posedge clk) begin
		if (en) begin
			d_s1     <= d_next;
			adcp_s1  <= raw_pressure;

			dt2_s2   <= d_s1 * t2;
			dsq_s2   <= $signed(dsq_full[41:0]);
			adcp_s2  <= adcp_s1;

			ssum_s3  <= ssum_next;
			adcp_s3  <= adcp_s2;

			sneg_s4  <= ssum_s3[59];
			smag_s4  <= ssum_s3[59] ? 59'(-ssum_s3) : 59'(ssum_s3);
			s5mag_s4 <= s5x[62] ? 62'(-s5x) : 62'(s5x);
			adcp_s4  <= adcp_s3;

			tres_s5  <= '{tc: tc_next, tf: tf_next};
			adcp_s5  <= adcp_s4;

			h_s6     <= 21'($signed(tres_s5.tf)) - baro_pkg::H_OFFSET;
			tres_s6  <= tres_s5;
			adcp_s6  <= adcp_s5;

			hh_s7    <= $signed(hh_full[40:0]);
			hp5_s7   <= h_s6 * p5;
			hp2_s7   <= h_s6 * p2;
			tres_s7  <= tres_s6;
			adcp_s7  <= adcp_s6;

			n2_s8    <= 60'(hh_p6) + (60'(hp5_s7) <<< 17) + (60'(p4) <<< 35);
			a_s8     <= baro_pkg::A_BIAS + 60'(hh_p3) + (60'(hp2_s7) <<< 20);
			tres_s8  <= tres_s7;
			adcp_s8  <= adcp_s7;

			ddp_s9   <= a_shr * $signed({1'b0, p1});
			x16_s9   <= $signed(x_diff[60:15]);
			tres_s9  <= tres_s8;

			dd_s10   <= $signed(ddp_s9[53:16]);
			num_s10  <= x16_s9 * baro_pkg::P_SCALE;
			tres_s10 <= tres_s9;

			un_s11    <= num_s10[59] ? 59'(-num_s10) : 59'(num_s10);
			ud_s11    <= dd_s10[37] ? 37'(-dd_s10) : 37'(dd_s10);
			neg_s11   <= num_s10[59] ^ dd_s10[37];
			inval_s11 <= (dd_s10 == '0);
			tres_s11  <= tres_s10;

			// Divider setup: saturation check and the leading partial remainder.
			div_s12.rem   <= 37'(un_s11[58:baro_pkg::INT_SHIFT]);
			div_s12.den   <= ud_s11;
			div_s12.lo    <= un_s11[baro_pkg::INT_SHIFT-1:0];
			div_s12.quo   <= '0;
			div_s12.neg   <= neg_s11;
			div_s12.sat   <= {1'b0, un_s11} >= {ud_s11, 23'b0};
			div_s12.inval <= inval_s11;
			div_s12.tres  <= tres_s11;
		end
	end

	// Restoring divider, one quotient bit per stage.
	genvar k;
	for (k = 1; k <= baro_pkg::DIV_BITS; k++) begin : g_div
		localparam int J = baro_pkg::DIV_BITS - k;
		baro_pkg::div_stage_t prev;
		baro_pkg::div_stage_t nxt;
		logic                 dbit;
		logic [37:0]          trial;
		logic                 ge;

		if (k == 1) begin : g_first
			assign prev = div_s12;
		end else begin : g_next
			assign prev = div_s[k-1];
		end

		if (J >= baro_pkg::FRAC_BITS) begin : g_int
			assign dbit = prev.lo[J-baro_pkg::FRAC_BITS];
		end else begin : g_frac
			assign dbit = 1'b0;
		end

		// Trial subtraction of the divisor from the shifted remainder.
		always_comb begin
			trial   = {prev.rem, dbit};
			ge      = trial >= {1'b0, prev.den};
			nxt     = prev;
			nxt.rem = ge ? 37'(trial - {1'b0, prev.den}) : trial[36:0];
			nxt.quo = {prev.quo[37:0], ge};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k] <= nxt;
			end
		end
	end

	// Back-end arithmetic: signed quotient, correction terms, rounding and clamping.
	always_comb begin
		pm      = div_s[baro_pkg::DIV_BITS].sat ? baro_pkg::P_SAT
			: {1'b0, div_s[baro_pkg::DIV_BITS].quo};
		pq_next = div_s[baro_pkg::DIV_BITS].neg ? -$signed({1'b0, pm}) : $signed({1'b0, pm});
		sq_sh   = $signed(pq_s52[40:8]);
		rq      = 33'((unsigned'(pf_s57) + baro_pkg::PA_HALF) >> 16);
		if (inval_s57 || pf_s57[48]) begin
			pa_next = '0;
		end else begin
			pa_next = (rq > 33'(baro_pkg::PA_MAX)) ? baro_pkg::PA_MAX : rq[17:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pq_s52    <= pq_next;
			tres_s52  <= div_s[baro_pkg::DIV_BITS].tres;
			inval_s52 <= div_s[baro_pkg::DIV_BITS].inval;

			sqa_s53   <= sq_sh[32] ? 32'(-sq_sh) : 32'(sq_sh);
			p8m_s53   <= pq_s52 * p8;
			pq_s53    <= pq_s52;
			tres_s53  <= tres_s52;
			inval_s53 <= inval_s52;

			sq2_s54   <= sqa_s53 * sqa_s53;
			p8t_s54   <= $signed(p8m_s53[56:15]);
			pq_s54    <= pq_s53;
			tres_s54  <= tres_s53;
			inval_s54 <= inval_s53;

			m9_s55    <= p9 * $signed({1'b0, sq2_s54[63:31]});
			p8t_s55   <= p8t_s54;
			pq_s55    <= pq_s54;
			tres_s55  <= tres_s54;
			inval_s55 <= inval_s54;

			corr_s56  <= 52'(m9_s55) + 52'(p8t_s55) + (52'(p7) <<< 16);
			pq_s56    <= pq_s55;
			tres_s56  <= tres_s55;
			inval_s56 <= inval_s55;

			pf_s57    <= 49'(pq_s56) + 49'($signed(corr_s56[51:4]));
			tres_s57  <= tres_s56;
			inval_s57 <= inval_s56;

			tc_s58    <= $signed(tres_s57.tc);
			tf_s58    <= $signed(tres_s57.tf);
			pa_s58    <= pa_next;
			inval_s58 <= inval_s57;
		end
	end

	// Output transaction.
	assign out_valid         = vld_s[baro_pkg::STAGES];
	assign temperature_centi = tc_s58;
	assign fine_temperature  = tf_s58;
	assign pressure_pa       = pa_s58;
	assign invalid           = inval_s58;

	// A zero divisor always reports zero pressure.
	a_inval_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid |-> pressure_pa == '0)
		else $error("invalid result with nonzero pressure");

	// The first stage fills only from an accepted input transaction.
	a_fill_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vld_s[1]) |-> $past(in_valid && !in_stall))
		else $error("first stage filled without an input transaction");

	// The divider remainder stays below the divisor when no saturation applies.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[LAST_DIV] && !div_s[baro_pkg::DIV_BITS].sat && !div_s[baro_pkg::DIV_BITS].inval
		|-> div_s[baro_pkg::DIV_BITS].rem < div_s[baro_pkg::DIV_BITS].den)
		else $error("divider remainder out of range");

endmodule

/* tb/baro_checker.sv */
`timescale 1ns / 1ps

module baro_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [19:0]        raw_pressure,
	input  logic [19:0]        raw_temperature,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [15:0] temperature_centi,
	input  logic [17:0]        pressure_pa,
	input  logic signed [19:0] fine_temperature,
	input  logic               invalid,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		logic signed [15:0] tc;
		logic [17:0]        pa;
		logic signed [19:0] tf;
		logic               inval;
	} reading_t;

	localparam longint P_LIMIT = 64'sd8388608;

	logic [31:0] calib [0:5];
	reading_t    expected_readings [$];

	// Divide by a power of two, rounding half away from zero.
	function automatic longint round_shift(longint v, int sh);
		longint m;
		longint q;
		m = (v < 0) ? -v : v;
		q = (m + (64'sd1 <<< (sh - 1))) >>> sh;
		return (v < 0) ? -q : q;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Fixed-point compensation of one pressure/temperature pair.
	function automatic reading_t compensate(logic [19:0] adc_p_raw, logic [19:0] adc_t_raw);
		longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		longint adc_p, adc_t, d, s, mag, tf, tc, h, n2, a, dd, x16, num, pq;
		longint sq, corr, pf, pa;
		longint unsigned un, ud, q0, r, pm;
		logic neg;
		reading_t res;
		t1 = longint'(calib[baro_pkg::REG_T1_T2][15:0]);
		t2 = longint'($signed(calib[baro_pkg::REG_T1_T2][31:16]));
		t3 = longint'($signed(calib[baro_pkg::REG_T3_P1][15:0]));
		p1 = longint'(calib[baro_pkg::REG_T3_P1][31:16]);
		p2 = longint'($signed(calib[baro_pkg::REG_P2_P3][15:0]));
		p3 = longint'($signed(calib[baro_pkg::REG_P2_P3][31:16]));
		p4 = longint'($signed(calib[baro_pkg::REG_P4_P5][15:0]));
		p5 = longint'($signed(calib[baro_pkg::REG_P4_P5][31:16]));
		p6 = longint'($signed(calib[baro_pkg::REG_P6_P7][15:0]));
		p7 = longint'($signed(calib[baro_pkg::REG_P6_P7][31:16]));
		p8 = longint'($signed(calib[baro_pkg::REG_P8_P9][15:0]));
		p9 = longint'($signed(calib[baro_pkg::REG_P8_P9][31:16]));
		adc_p = longint'(adc_p_raw);
		adc_t = longint'(adc_t_raw);
		pa = 0;
		res.inval = 1'b0;

		// Temperature path is exact.
		d = adc_t - 16 * t1;
		s = d * t2 * 64'sd1048576 + d * d * t3;
		mag = (s < 0) ? -s : s;
		tf = mag >>> 34;
		if (s < 0) begin
			tf = -tf;
		end
		tf = clip(tf, -524288, 524287);
		tc = clip(round_shift(s * 5, 42), -32768, 32767);

		// Pressure divisor and dividend.
		h = tf - 128000;
		n2 = h * h * p6 + h * p5 * 64'sd131072 + p4 * (64'sd1 <<< 35);
		a = (64'sd1 <<< 55) + p3 * h * h + p2 * h * 64'sd1048576;
		dd = ((a >>> 23) * p1) >>> 16;
		if (dd == 0) begin
			res.inval = 1'b1;
		end else begin
			x16 = ((64'sd1048576 - adc_p) * (64'sd1 <<< 31) - n2) >>> 15;
			num = x16 * 6250;
			un = (num < 0) ? longint'(-num) : num;
			ud = (dd < 0) ? longint'(-dd) : dd;
			neg = (num < 0) != (dd < 0);
			q0 = un / ud;
			r = un % ud;
			if (q0 >= P_LIMIT) begin
				pm = P_LIMIT << 16;
			end else begin
				pm = (q0 << 16) + ((r << 16) / ud);
			end
			pq = neg ? -longint'(pm) : longint'(pm);
			// Second-order correction terms.
			sq = pq >>> 8;
			sq = sq * sq;
			corr = p9 * (sq >>> 31) + ((pq * p8) >>> 15) + p7 * 64'sd65536;
			pf = pq + (corr >>> 4);
			pa = clip(round_shift(pf, 16), 0, 262143);
		end
		res.tc = tc[15:0];
		res.pa = pa[17:0];
		res.tf = tf[19:0];
		return res;
	endfunction

	// Track register writes, accepted inputs and produced results.
	always @(posedge clk or negedge arst_n) begin
		reading_t got;
		reading_t want;
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				calib[i] = '0;
			end
			expected_readings.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready && cfg_index <= baro_pkg::REG_P8_P9) begin
				calib[cfg_index] = cfg_data;
			end
			if (in_valid && !in_stall) begin
				expected_readings.push_back(compensate(raw_pressure, raw_temperature));
			end
			if (out_valid && !out_stall) begin
				got = {temperature_centi, pressure_pa, fine_temperature, invalid};
				if (expected_readings.size() == 0) begin
					if (errors < 10) begin
						$display("Unexpected result transaction: tc=%0d pa=%0d tf=%0d inv=%0b",
							got.tc, got.pa, got.tf, got.inval);
					end
					errors <= errors + 1;
				end else begin
					want = expected_readings.pop_front();
					if (got !== want) begin
						if (errors < 10) begin
							$display({"Mismatch: expected tc=%0d pa=%0d tf=%0d inv=%0b,",
								" got tc=%0d pa=%0d tf=%0d inv=%0b"},
								want.tc, want.pa, want.tf, want.inval,
								got.tc, got.pa, got.tf, got.inval);
						end
						errors <= errors + 1;
					end
				end
			end
			pending <= expected_readings.size();
		end
	end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	localparam logic [2:0] IDX_SPARE_LO = 3'd6;
	localparam logic [2:0] IDX_SPARE_HI = 3'd7;
	localparam int DRAIN_CYCLES = baro_pkg::STAGES + 20;
	localparam int CYCLE_LIMIT  = 600000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [19:0]        raw_pressure;
	logic [19:0]        raw_temperature;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] temperature_centi;
	logic [17:0]        pressure_pa;
	logic signed [19:0] fine_temperature;
	logic               invalid;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;
	int                 errors;
	int                 pending;
	int                 send_idle_pct;
	int                 recv_idle_pct;
	int                 hold_request;
	int                 cycle_count;

	baro_sensor_compensation u_top (.*);

	baro_checker u_checker (.*);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Cycle limit.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Result side: random stall, plus long hold-offs on request.
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall = 1'b1;
			end else begin
				out_stall = ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Offer one reading and hold it until accepted. Called at a falling edge.
	task automatic send_reading(logic [19:0] p, logic [19:0] t);
		logic stalled;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			raw_pressure = 20'($urandom);
			raw_temperature = 20'($urandom);
			@(negedge clk);
		end
		in_valid = 1'b1;
		raw_pressure = p;
		raw_temperature = t;
		do begin
			#1;
			stalled = in_stall;
			@(negedge clk);
		end while (stalled);
		in_valid = 1'b0;
	endtask

	task automatic write_calib(logic [2:0] idx, logic [31:0] value);
		logic ready;
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do begin
			#1;
			ready = cfg_ready;
			@(negedge clk);
		end while (!ready);
		cfg_valid = 1'b0;
	endtask

	// Let every outstanding transaction come out before touching registers.
	task automatic drain();
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic load_calib(logic [31:0] r0, logic [31:0] r1, logic [31:0] r2,
			logic [31:0] r3, logic [31:0] r4, logic [31:0] r5);
		write_calib(baro_pkg::REG_T1_T2, r0);
		write_calib(baro_pkg::REG_T3_P1, r1);
		write_calib(baro_pkg::REG_P2_P3, r2);
		write_calib(baro_pkg::REG_P4_P5, r3);
		write_calib(baro_pkg::REG_P6_P7, r4);
		write_calib(baro_pkg::REG_P8_P9, r5);
	endtask

	// Typical sensor calibration, with each coefficient nudged by up to +/- jitter.
	task automatic load_typical(int jitter);
		logic [15:0] c [12];
		int base [12] = '{27504, 26435, -1000, 36477, -10685, 3024,
			2855, 140, -7, 15500, -14600, 6000};
		for (int i = 0; i < 12; i++) begin
			c[i] = 16'(base[i] + $urandom_range(2 * jitter) - jitter);
		end
		load_calib({c[1], c[0]}, {c[3], c[2]}, {c[5], c[4]},
			{c[7], c[6]}, {c[9], c[8]}, {c[11], c[10]});
	endtask

	// Mostly readings near a real operating point, some over the whole range.
	task automatic random_readings(int count);
		logic [19:0] p;
		logic [19:0] t;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 70) begin
				p = 20'(415148 + $urandom_range(200000) - 100000);
				t = 20'(519888 + $urandom_range(120000) - 60000);
			end else begin
				p = 20'($urandom);
				t = 20'($urandom);
			end
			send_reading(p, t);
		end
	endtask

	// Random section, split into three idling modes by the running item count.
	task automatic random_phase(int count, ref int sent);
		for (int i = 0; i < count; i++) begin
			if (sent < 480) begin
				send_idle_pct = 29;
				recv_idle_pct = 55;
			end else if (sent < 960) begin
				send_idle_pct = 55;
				recv_idle_pct = 29;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			random_readings(1);
			sent++;
		end
	endtask

	// Stimulus and verdict.
	initial begin
		int sent;
		sent = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		raw_pressure = '0;
		raw_temperature = '0;
		cfg_valid = 1'b0;
		cfg_index = baro_pkg::REG_T1_T2;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset calibration: divisor is zero, so every result is invalid.
		send_reading(20'h00000, 20'h00000);
		send_reading(20'hfffff, 20'hfffff);
		send_reading(20'd415148, 20'd519888);
		drain();

		// Typical calibration, field extremes and writes to unused indexes.
		load_typical(0);
		write_calib(IDX_SPARE_LO, 32'hffffffff);
		write_calib(IDX_SPARE_HI, 32'h12345678);
		send_reading(20'd415148, 20'd519888);
		send_reading(20'h00000, 20'h00000);
		send_reading(20'hfffff, 20'hfffff);
		send_reading(20'h00000, 20'hfffff);
		send_reading(20'hfffff, 20'h00000);
		send_reading(20'h55555, 20'haaaaa);
		send_reading(20'haaaaa, 20'h55555);
		send_reading(20'd300000, 20'd519888);
		send_reading(20'd600000, 20'd519888);
		send_reading(20'd415148, 20'd440064);
		drain();

		// Extreme coefficients: saturated temperature, huge quotient, clamped pressure.
		load_calib(32'h7fff0000, 32'hffff7fff, 32'h80007fff,
			32'h7fff8000, 32'h80007fff, 32'h7fff8000);
		send_reading(20'h00000, 20'hfffff);
		send_reading(20'hfffff, 20'h00000);
		send_reading(20'h80000, 20'h80000);
		drain();
		load_calib(32'h8000ffff, 32'h00018000, 32'h7fff8000,
			32'h80007fff, 32'h7fff8000, 32'h80007fff);
		send_reading(20'h00000, 20'hfffff);
		send_reading(20'hfffff, 20'h00000);
		send_reading(20'h12345, 20'h80000);
		drain();

		// Long hold-off on the result side while readings keep coming.
		load_typical(0);
		hold_request = 300;
		random_readings(150);
		drain();

		// Random sections over several calibrations.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0, 2, 4: begin
					load_typical(ph * 200);
				end
				1: begin
					load_calib($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
				end
				3: begin
					load_calib(32'hffffffff, 32'hffffffff, 32'hffffffff,
						32'hffffffff, 32'hffffffff, 32'hffffffff);
				end
				default: begin
					load_typical(3000);
				end
			endcase
			random_phase(215, sent);
			drain();
		end

		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
